// File: rtl/core/assert_macros.svh
// Assertion helper macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mhpt_pkg.sv
// ----------------------------------------------------------------------------
// mhpt_pkg
// Shared constants and types for the min-heap priority table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mhpt_pkg;
  localparam int Capacity = 256;
  localparam int AddrW    = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int EntryW   = 64;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic signed [31:0] key;
    logic        [31:0] value;
  } entry_t;

  typedef struct packed {
    logic         we;
    logic [AddrW-1:0] waddr;
    entry_t       wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;
endpackage
`default_nettype wire

// File: rtl/core/mhpt_ram.sv
// ----------------------------------------------------------------------------
// mhpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mhpt_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/core/mhpt_ctrl.sv
// ----------------------------------------------------------------------------
// mhpt_ctrl
// Sequencer: scan, move and sift over the entry RAM, one access per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mhpt_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [1:0]                op,
  input  wire mhpt_pkg::entry_t          in_entry,
  output logic                           busy,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [mhpt_pkg::CntW-1:0]      count,
  output mhpt_pkg::entry_t               root,
  output mhpt_pkg::mem_req_t             mreq,
  input  wire mhpt_pkg::entry_t          rdata
);
  import mhpt_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SCAN  = 10'b0000000010,
    S_LAST  = 10'b0000000100,
    S_UPRD  = 10'b0000001000,
    S_UPCMP = 10'b0000010000,
    S_DNRL  = 10'b0000100000,
    S_DNRR  = 10'b0001000000,
    S_DNCMP = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_WAIT  = 10'b1000000000
  } state_t;

  state_t state;
  logic [CntW-1:0]  cnt;
  logic [1:0]       cur_op;
  entry_t           arg;
  entry_t           cur;      // entry being sifted
  entry_t           lchild;
  logic [CntW-1:0]  pos;      // slot of cur (hole)
  logic [CntW-1:0]  idx;      // scan index
  logic             scan_vld; // a read is in flight for idx-1
  logic [CntW:0]    lpos;

  always_comb begin
    lpos = {pos, 1'b0} + (CntW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur_op <= op;
            arg    <= in_entry;
            status <= ST_OK;
            case (op)
              OP_INSERT: begin
                if (cnt >= CntW'(Capacity)) begin
                  status <= ST_FULL;
                  state  <= S_FIN;
                end else begin
                  cur   <= in_entry;
                  pos   <= cnt;
                  cnt   <= cnt + 1'b1;
                  state <= S_UPRD;
                end
              end
              OP_DELETE, OP_FIND: begin
                idx      <= '0;
                scan_vld <= 1'b0;
                state    <= S_SCAN;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_SCAN: begin
          // read slot idx this cycle, compare slot idx-1 data
          if (scan_vld && ((cur_op == OP_DELETE) ? (rdata.key == arg.key)
                                                 : (rdata.value == arg.value))) begin
            pos <= idx - 1'b1;
            if (cur_op == OP_FIND) begin
              state <= S_FIN;
            end else begin
              cnt   <= cnt - 1'b1;
              state <= S_LAST;
            end
          end else if (idx >= cnt) begin
            status <= ST_NOTFOUND;
            state  <= S_FIN;
          end else begin
            idx      <= idx + 1'b1;
            scan_vld <= 1'b1;
          end
        end
        S_LAST: begin
          // read of slot cnt (old last) issued in this cycle; result next
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (pos >= cnt) begin
            state <= S_FIN;
          end else begin
            cur   <= rdata;
            state <= S_UPRD;
          end
        end
        S_UPRD: begin
          if (pos == '0) begin
            state <= S_DNRL;
          end else begin
            state <= S_UPCMP;
          end
        end
        S_UPCMP: begin
          if (cur.key < rdata.key) begin
            // parent moves down into the hole
            pos   <= (pos - 1'b1) >> 1;
            state <= S_UPRD;
          end else begin
            state <= (cur_op == OP_DELETE) ? S_DNRL : S_FIN;
          end
        end
        S_DNRL: begin
          if (lpos >= {1'b0, cnt}) begin
            state <= S_FIN;
          end else begin
            state <= S_DNRR;
          end
        end
        S_DNRR: begin
          lchild <= rdata;
          state  <= S_DNCMP;
        end
        S_DNCMP: begin
          if ((lpos + 1'b1 < {1'b0, cnt}) && (rdata.key < lchild.key)) begin
            if (rdata.key < cur.key) begin
              pos   <= CntW'(lpos + 1'b1);
              state <= S_DNRL;
            end else begin
              state <= S_FIN;
            end
          end else if (lchild.key < cur.key) begin
            pos   <= CntW'(lpos);
            state <= S_DNRL;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Root shadow: slot 0 kept in a register, updated on every write to it.
  always_ff @(posedge clk) begin
    if (mreq.we && mreq.waddr == '0) begin
      root <= mreq.wdata;
    end
  end

  // Memory access per state. Writes place cur in its hole, or move a
  // neighbor (parent or child) into the hole.
  always_comb begin
    mreq       = '0;
    mreq.wdata = cur;
    mreq.waddr = pos[AddrW-1:0];
    case (state)
      S_IDLE:  mreq.raddr = '0;
      S_SCAN:  mreq.raddr = idx[AddrW-1:0];
      S_LAST:  mreq.raddr = cnt[AddrW-1:0];
      S_UPRD: begin
        mreq.raddr = AddrW'((pos - 1'b1) >> 1);
        mreq.we    = (pos == '0);
      end
      S_UPCMP: begin
        if (cur.key < rdata.key) begin
          mreq.we    = 1'b1;
          mreq.wdata = rdata;
        end else begin
          mreq.we = (cur_op != OP_DELETE);
        end
      end
      S_DNRL: begin
        mreq.raddr = lpos[AddrW-1:0];
        mreq.we    = (lpos >= {1'b0, cnt});
      end
      S_DNRR:  mreq.raddr = AddrW'(lpos + 1'b1);
      S_DNCMP: begin
        mreq.we = 1'b1;
        if ((lpos + 1'b1 < {1'b0, cnt}) && (rdata.key < lchild.key)) begin
          if (rdata.key < cur.key) mreq.wdata = rdata;
        end else if (lchild.key < cur.key) begin
          mreq.wdata = lchild;
        end
      end
      default: mreq.raddr = '0;
    endcase
  end

  assign busy  = (state != S_IDLE);
  assign count = cnt;
endmodule
`default_nettype wire

// File: rtl/core/min_heap_priority_table_core.sv
// ----------------------------------------------------------------------------
// min_heap_priority_table_core
// Binary min-heap of signed key / value entries held in one entry RAM.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata (low bit up)                                tuser
// s_axis   in   op[1:0], key[33:2], value[65:34], pad to 72       -
// m_axis   out  status[1:0], count[10:2], min_valid[11],          -
//               min_key[43:12], min_value[75:44], pad to 80
//
// Steps: insert sifts its entry up, one level per parent read and compare;
// on reaching the root the entry also passes through the sift-down states.
// Delete and find scan one slot per cycle; delete then fetches the last entry
// and sifts it up (parent read, compare), then down (left read, right read,
// compare). One RAM read per cycle, with registered read data, sets the pace.
// Reset clears the count and the sequencer; RAM contents are don't-care.
// s_axis stalls while an item is worked, in the cycle its result is loaded,
// and while the result register holds a result that is not being taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module min_heap_priority_table_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // op, key, value
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata    // status, count, min_valid, min_key, min_value
);
  import mhpt_pkg::*;

  logic            busy, done;
  logic [1:0]      status;
  logic [CntW-1:0] count;
  entry_t          root, rdata, in_entry;
  mem_req_t        mreq;
  logic            start;

  assign in_entry.key   = s_axis_tdata[33:2];
  assign in_entry.value = s_axis_tdata[65:34];
  // accept when sequencer idle, no result loading, and result slot free or draining
  assign s_axis_tready  = !busy && !done && (!m_axis_tvalid || m_axis_tready);
  assign start          = s_axis_tvalid && s_axis_tready;

  mhpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .op       (s_axis_tdata[1:0]),
    .in_entry (in_entry),
    .busy     (busy),
    .done     (done),
    .status   (status),
    .count    (count),
    .root     (root),
    .mreq     (mreq),
    .rdata    (rdata)
  );

  mhpt_ram #(.Width(EntryW), .Depth(Capacity)) u_ram (
    .clk   (clk),
    .we    (mreq.we),
    .waddr (mreq.waddr),
    .wdata (mreq.wdata),
    .raddr (mreq.raddr),
    .rdata (rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_axis_tdata[1:0]   <= status;
      m_axis_tdata[10:2]  <= 9'(count);
      m_axis_tdata[11]    <= (count != '0);
      m_axis_tdata[43:12] <= (count != '0) ? root.key : '0;
      m_axis_tdata[75:44] <= (count != '0) ? root.value : '0;
      m_axis_tdata[79:76] <= '0;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/mhpt_checker.sv
// ----------------------------------------------------------------------------
// mhpt_checker
// Port-level checks for the min-heap priority table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mhpt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [79:0] m_axis_tdata
);
  logic [1:0]  r_status;
  logic [8:0]  r_count;
  logic        r_minv;
  logic [63:0] r_min;
  logic        in_xfer;
  logic        out_free;

  assign r_status = m_axis_tdata[1:0];
  assign r_count  = m_axis_tdata[10:2];
  assign r_minv   = m_axis_tdata[11];
  assign r_min    = m_axis_tdata[75:12];
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  `ASSERT_IMPL(a_minv, clk, rst, m_axis_tvalid, r_minv == (r_count != 9'd0), "min_valid vs count")
  `ASSERT_IMPL(a_empty, clk, rst, m_axis_tvalid && !r_minv, r_min == 64'd0, "empty heap minimum")
  `ASSERT_IMPL(a_stat, clk, rst, m_axis_tvalid, r_status != 2'd3, "illegal status")
  `ASSERT_IMPL(a_gate, clk, rst, in_xfer, out_free, "input taken while result stalled")
  `ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule

bind min_heap_priority_table_core mhpt_checker u_checker (.*);
`default_nettype wire
